/* sv/weighted_count_cluster_stats_top_macros.svh */
// assertion macros for the cluster statistics block
`ifndef WEIGHTED_COUNT_CLUSTER_STATS_TOP_MACROS_SVH
`define WEIGHTED_COUNT_CLUSTER_STATS_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WCCS_ASSERT_SAME(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("wccs check failed");
`define WCCS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("wccs check failed");
`else
`define WCCS_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define WCCS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

/* sv/wccs_pkg.sv */
// constants and saturating helpers for the cluster statistics block
package wccs_pkg;
  localparam int MAX_CAT = 8;
  localparam int POS_W   = 3;
  localparam int CNT_W   = 4;
  localparam int W_W     = 48;
  localparam int MU_W    = 34;
  localparam int SS_W    = 64;
  localparam int MA_W    = 52;
  localparam int MB_W    = 26;
  localparam int PR_W    = MA_W + MB_W;
  localparam int ACC_W   = PR_W + MB_W;
  localparam int Q_W     = 40;
  localparam int SH_R    = 44;

  localparam logic [W_W-1:0] WMAX = {W_W{1'b1}};
  localparam logic signed [MU_W+7:0] MU_MAX = 42'sd8589934591;
  localparam logic signed [MU_W+7:0] MU_MIN = -42'sd8589934592;

  function automatic logic signed [SS_W-1:0] sat_add(input logic signed [SS_W-1:0] a,
                                                     input logic signed [SS_W-1:0] b);
    logic signed [SS_W:0] s;
    s = {a[SS_W-1], a} + {b[SS_W-1], b};
    if (s[SS_W] != s[SS_W-1]) begin
      sat_add = s[SS_W] ? {1'b1, {(SS_W-1){1'b0}}} : {1'b0, {(SS_W-1){1'b1}}};
    end else begin
      sat_add = s[SS_W-1:0];
    end
  endfunction

  function automatic logic signed [SS_W-1:0] sat_sub(input logic signed [SS_W-1:0] a,
                                                     input logic signed [SS_W-1:0] b);
    logic signed [SS_W:0] s;
    s = {a[SS_W-1], a} - {b[SS_W-1], b};
    if (s[SS_W] != s[SS_W-1]) begin
      sat_sub = s[SS_W] ? {1'b1, {(SS_W-1){1'b0}}} : {1'b0, {(SS_W-1){1'b1}}};
    end else begin
      sat_sub = s[SS_W-1:0];
    end
  endfunction
endpackage

/* sv/weighted_count_cluster_stats_top.sv */
// weighted running mean and sum of squares of one cluster, add or remove
//
//  channel | ports                                     | direction
//  in      | in_valid in_ready in_mode in_total_size   | word in
//          | in_count in_last                          |
//  out     | out_valid out_ready out_score out_total_ss| word out, on last
//  cfg     | cfg_we cfg_wdata                          | register write
//
// an element that updates a category runs the restoring divider by the
// weight sum for a 40-bit quotient, and makes six passes through the
// one 52x26 multiplier and the accumulate steps; the divider is skipped
// when the quotient saturates; a last word also passes the hand-over state
// reset is synchronous and clears all statistics at once
// the input stalls while an element is in work; a held result stalls the
// block at the next last word until it is taken
`include "weighted_count_cluster_stats_top_macros.svh"

module weighted_count_cluster_stats_top import wccs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [15:0]            in_total_size,
  input  logic [15:0]            in_count,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [63:0]     out_score,
  output logic signed [63:0]     out_total_ss,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_wdata
);

  typedef enum logic [17:0] {
    S_IDLE = 18'b000000000000000001,
    S_SQ   = 18'b000000000000000010,
    S_HEAD = 18'b000000000000000100,
    S_CHK  = 18'b000000000000001000,
    S_M1   = 18'b000000000000010000,
    S_A    = 18'b000000000000100000,
    S_M2   = 18'b000000000001000000,
    S_DI   = 18'b000000000010000000,
    S_DIV  = 18'b000000000100000000,
    S_NM   = 18'b000000001000000000,
    S_M3   = 18'b000000010000000000,
    S_B    = 18'b000000100000000000,
    S_M4   = 18'b000001000000000000,
    S_M5   = 18'b000010000000000000,
    S_T    = 18'b000100000000000000,
    S_ACC  = 18'b001000000000000000,
    S_ADV  = 18'b010000000000000000,
    S_EMIT = 18'b100000000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]              ac_r;
  logic [W_W-1:0]                weight_r;
  logic signed [MU_W-1:0]        mean_r [MAX_CAT];
  logic signed [SS_W-1:0]        css_r  [MAX_CAT];
  logic signed [SS_W-1:0]        sum_ss_r;
  logic signed [SS_W-1:0]        ss_before_r;
  logic [POS_W-1:0]              pos_r;
  logic                          clear_r;

  logic                          mode_r, last_r;
  logic [15:0]                   s_r, x_r;
  logic [PR_W-1:0]               prod_r;
  logic [ACC_W-1:0]              acc_r;
  logic signed [MA_W-1:0]        a_r, b_r;
  logic signed [MU_W-1:0]        nm_r;
  logic [W_W-1:0]                rem_r;
  logic [Q_W-1:0]                qd_r;
  logic                          qsat_r;
  logic [5:0]                    cnt_r;
  logic signed [SS_W-1:0]        t_r;
  logic                          out_valid_r;
  logic signed [SS_W-1:0]        out_score_r, out_total_r;

  logic [CNT_W-1:0]              limit;
  logic [MA_W-1:0]               mul_a;
  logic [MB_W-1:0]               mul_b;
  logic signed [MU_W-1:0]        m_cur;
  logic [MU_W-1:0]               m_mag, nm_mag;
  logic [MA_W-1:0]               a_mag, b_mag;
  logic signed [MA_W-1:0]        xs;
  logic [W_W:0]                  div_t;
  logic                          div_ge;
  logic [W_W-1:0]                sq_w;
  logic signed [MU_W+7:0]        nm_w, m_ext, q_ext;
  logic signed [MU_W-1:0]        nm_c;
  logic [ACC_W-1:0]              full_p;
  logic [SS_W-1:0]               r_mag;
  logic                          emit_go;

  assign limit  = (ac_r > CNT_W'(MAX_CAT)) ? CNT_W'(MAX_CAT) : ac_r;
  assign m_cur  = mean_r[pos_r];
  assign m_mag  = m_cur[MU_W-1] ? (~m_cur + 1'b1) : m_cur;
  assign nm_mag = nm_r[MU_W-1] ? (~nm_r + 1'b1) : nm_r;
  assign a_mag  = a_r[MA_W-1] ? (~a_r + 1'b1) : a_r;
  assign b_mag  = b_r[MA_W-1] ? (~b_r + 1'b1) : b_r;
  assign xs     = {6'b0, x_r, 30'b0};
  assign sq_w   = {16'b0, prod_r[31:0]};
  assign div_t  = {rem_r, qd_r[Q_W-1]};
  assign div_ge = div_t >= {1'b0, weight_r};
  assign emit_go = !out_valid_r || out_ready;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: begin
        mul_a = MA_W'(s_r);
        mul_b = MB_W'(s_r);
      end
      S_M1: begin
        mul_a = MA_W'(m_mag);
        mul_b = MB_W'(s_r);
      end
      S_M2: begin
        mul_a = a_mag;
        mul_b = MB_W'(s_r);
      end
      S_M3: begin
        mul_a = MA_W'(nm_mag);
        mul_b = MB_W'(s_r);
      end
      S_M4: begin
        mul_a = a_mag;
        mul_b = b_mag[MB_W-1:0];
      end
      S_M5: begin
        mul_a = a_mag;
        mul_b = b_mag[MA_W-1:MB_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    m_ext = {{8{m_cur[MU_W-1]}}, m_cur};
    q_ext = qsat_r ? (42'sd1 <<< Q_W) : {2'b0, qd_r};
    nm_w  = (a_r[MA_W-1] ^ mode_r) ? (m_ext - q_ext) : (m_ext + q_ext);
    if (nm_w > MU_MAX) begin
      nm_c = MU_MAX[MU_W-1:0];
    end else if (nm_w < MU_MIN) begin
      nm_c = MU_MIN[MU_W-1:0];
    end else begin
      nm_c = nm_w[MU_W-1:0];
    end
    full_p = acc_r + {prod_r, {MB_W{1'b0}}};
    r_mag  = SS_W'(full_p[ACC_W-1:SH_R]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_HEAD;
      S_HEAD: state_nxt = S_CHK;
      S_CHK: begin
        if (!clear_r && ({1'b0, pos_r} < limit) && (weight_r != '0)) begin
          state_nxt = S_M1;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_M1:  state_nxt = S_A;
      S_A:   state_nxt = S_M2;
      S_M2:  state_nxt = S_DI;
      S_DI:  state_nxt = ({10'b0, prod_r[PR_W-1:Q_W]} >= weight_r) ? S_NM : S_DIV;
      S_DIV: if (cnt_r == 6'(Q_W - 1)) state_nxt = S_NM;
      S_NM:  state_nxt = S_M3;
      S_M3:  state_nxt = S_B;
      S_B:   state_nxt = S_M4;
      S_M4:  state_nxt = S_M5;
      S_M5:  state_nxt = S_T;
      S_T:   state_nxt = S_ACC;
      S_ACC: state_nxt = S_ADV;
      S_ADV: state_nxt = last_r ? S_EMIT : S_IDLE;
      S_EMIT: if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ac_r        <= CNT_W'(MAX_CAT);
      weight_r    <= '0;
      sum_ss_r    <= '0;
      ss_before_r <= '0;
      pos_r       <= '0;
      clear_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CAT; i++) begin
        mean_r[i] <= '0;
        css_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) ac_r <= cfg_wdata;
      if ((state_r == S_EMIT) && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_mode;
            s_r    <= in_total_size;
            x_r    <= in_count;
            last_r <= in_last;
          end
        end
        S_SQ: prod_r <= PR_W'(mul_a * mul_b);
        S_HEAD: begin
          if (pos_r == '0 && !clear_r) begin
            ss_before_r <= sum_ss_r;
            if (s_r == '0) begin
              clear_r <= 1'b1;
            end else if (!mode_r) begin
              weight_r <= (weight_r > (WMAX - sq_w)) ? WMAX : (weight_r + sq_w);
            end else if (sq_w >= weight_r) begin
              weight_r <= '0;
              sum_ss_r <= '0;
              clear_r  <= 1'b1;
              for (int i = 0; i < MAX_CAT; i++) begin
                mean_r[i] <= '0;
                css_r[i]  <= '0;
              end
            end else begin
              weight_r <= weight_r - sq_w;
            end
            if (limit == '0) clear_r <= 1'b1;
          end
        end
        S_CHK: ;
        S_M1, S_M2, S_M3, S_M4: prod_r <= PR_W'(mul_a * mul_b);
        S_A: begin
          a_r <= m_cur[MU_W-1] ? (xs + signed'(prod_r[MA_W-1:0]))
                               : (xs - signed'(prod_r[MA_W-1:0]));
        end
        S_DI: begin
          qsat_r <= {10'b0, prod_r[PR_W-1:Q_W]} >= weight_r;
          rem_r  <= {10'b0, prod_r[PR_W-1:Q_W]};
          qd_r   <= prod_r[Q_W-1:0];
          cnt_r  <= '0;
        end
        S_DIV: begin
          rem_r <= div_ge ? W_W'(div_t - {1'b0, weight_r}) : div_t[W_W-1:0];
          qd_r  <= {qd_r[Q_W-2:0], div_ge};
          cnt_r <= cnt_r + 6'd1;
        end
        S_NM: begin
          mean_r[pos_r] <= nm_c;
          nm_r          <= nm_c;
        end
        S_B: begin
          b_r <= nm_r[MU_W-1] ? (xs + signed'(prod_r[MA_W-1:0]))
                              : (xs - signed'(prod_r[MA_W-1:0]));
        end
        S_M5: begin
          acc_r  <= ACC_W'(prod_r);
          prod_r <= PR_W'(mul_a * mul_b);
        end
        S_T: begin
          t_r <= (a_r[MA_W-1] ^ b_r[MA_W-1] ^ mode_r) ? -signed'(r_mag) : signed'(r_mag);
        end
        S_ACC: begin
          css_r[pos_r] <= sat_add(css_r[pos_r], t_r);
          sum_ss_r     <= sat_add(sum_ss_r, t_r);
        end
        S_ADV: begin
          if (!clear_r) begin
            if (({1'b0, pos_r} + CNT_W'(1)) >= limit) begin
              clear_r <= 1'b1;
            end else begin
              pos_r <= pos_r + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_score_r <= mode_r ? '0 : sat_sub(ss_before_r, sum_ss_r);
            out_total_r <= sum_ss_r;
            pos_r       <= '0;
            clear_r     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_score    = out_score_r;
  assign out_total_ss = out_total_r;

  `WCCS_ASSERT_SAME(a_div_rem, clk, rst_n, state_r == S_DIV, rem_r < weight_r)
  `WCCS_ASSERT_SAME(a_upd_live, clk, rst_n, state_r == S_M1, (weight_r != '0) && !clear_r)
  `WCCS_ASSERT_NEXT(a_emit, clk, rst_n, (state_r == S_EMIT) && emit_go, out_valid_r && (state_r == S_IDLE))

endmodule

/* sim/weighted_count_cluster_stats_checker.sv */
// checker: predicts the cluster statistics and compares every result word
`timescale 1ns / 1ps

module weighted_count_cluster_stats_checker import wccs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_mode,
  input  logic [15:0]        in_total_size,
  input  logic [15:0]        in_count,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [63:0] out_score,
  input  logic signed [63:0] out_total_ss,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  output int                 failures,
  output int                 pending
);

  localparam logic signed [63:0] MEAN_HI = 64'sd8589934591;
  localparam logic signed [63:0] MEAN_LO = -64'sd8589934592;
  localparam logic [63:0] WEIGHT_TOP = 64'h0000_ffff_ffff_ffff;

  typedef struct packed {
    logic signed [63:0] score;
    logic signed [63:0] total_ss;
  } stats_word_t;

  stats_word_t        stats_due[$];
  logic [3:0]         n_cats;
  logic [63:0]        weight;
  logic signed [63:0] mean[MAX_CAT];
  logic signed [63:0] cat_ss[MAX_CAT];
  logic signed [63:0] tot_ss;
  logic signed [63:0] ss_latched;
  int                 pos;
  bit                 skip;

  function automatic logic signed [63:0] clip_sum(logic signed [63:0] a, logic signed [63:0] b,
                                                  bit subtract);
    logic signed [64:0] r;
    r = subtract ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
    if (r[64] != r[63]) return r[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    return r[63:0];
  endfunction

  task automatic clear_stats();
    weight = '0;
    tot_ss = '0;
    for (int j = 0; j < MAX_CAT; j++) begin
      mean[j] = '0;
      cat_ss[j] = '0;
    end
  endtask

  task automatic update_cat(int j, bit rem, logic [15:0] s, logic [15:0] x);
    logic signed [63:0] m, xs, s64, a, b, nm, t;
    logic [63:0]        amag, bmag, q, r;
    logic [127:0]       p, quot;
    bit                 neg;
    m = mean[j];
    s64 = $signed({48'b0, s});
    xs = $signed({18'b0, x, 30'b0});
    a = xs - m * s64;
    amag = a[63] ? -a : a;
    p = {64'b0, amag} * {112'b0, s};
    quot = p / {64'b0, weight};
    q = (quot > 128'd1099511627776) ? 64'd1099511627776 : quot[63:0];
    neg = a[63] != rem;
    nm = neg ? m - $signed(q) : m + $signed(q);
    if (nm > MEAN_HI) nm = MEAN_HI;
    if (nm < MEAN_LO) nm = MEAN_LO;
    mean[j] = nm;
    b = xs - nm * s64;
    bmag = b[63] ? -b : b;
    p = {64'b0, amag} * {64'b0, bmag};
    r = p[107:44];
    neg = (a[63] != b[63]) != rem;
    t = neg ? -$signed(r) : $signed(r);
    cat_ss[j] = clip_sum(cat_ss[j], t, 1'b0);
    tot_ss = clip_sum(tot_ss, t, 1'b0);
  endtask

  task automatic take_word(bit rem, logic [15:0] s, logic [15:0] x, bit lst);
    int          limit;
    logic [63:0] w;
    stats_word_t res;
    limit = (n_cats > MAX_CAT) ? MAX_CAT : n_cats;
    if (pos == 0 && !skip) begin
      w = s * s;
      ss_latched = tot_ss;
      if (s == 0) begin
        skip = 1;
      end else if (!rem) begin
        weight = (weight > WEIGHT_TOP - w) ? WEIGHT_TOP : weight + w;
      end else if (w >= weight) begin
        clear_stats();
        skip = 1;
      end else begin
        weight = weight - w;
      end
      if (limit == 0) skip = 1;
    end
    if (!skip) begin
      if (pos < limit && weight != 0) update_cat(pos, rem, s, x);
      if (pos + 1 >= limit) skip = 1;
      else pos++;
    end
    if (lst) begin
      res.score = rem ? 64'sd0 : clip_sum(ss_latched, tot_ss, 1'b1);
      res.total_ss = tot_ss;
      stats_due.push_back(res);
      pos = 0;
      skip = 0;
    end
  endtask

  always @(posedge clk) begin
    stats_word_t exp_w;
    if (!rst_n) begin
      n_cats = 4'd8;
      clear_stats();
      ss_latched = '0;
      pos = 0;
      skip = 0;
      failures = 0;
      stats_due.delete();
    end else begin
      if (cfg_we) n_cats = cfg_wdata;
      if (in_valid && in_ready) take_word(in_mode, in_total_size, in_count, in_last);
      if (out_valid && out_ready) begin
        if (stats_due.size() == 0) begin
          $error("result word with nothing expected");
          failures++;
        end else begin
          exp_w = stats_due.pop_front();
          if (out_score !== exp_w.score) begin
            $error("score: expected %0d, got %0d", exp_w.score, out_score);
            failures++;
          end
          if (out_total_ss !== exp_w.total_ss) begin
            $error("total_ss: expected %0d, got %0d", exp_w.total_ss, out_total_ss);
            failures++;
          end
        end
      end
    end
    pending = stats_due.size();
  end
endmodule

/* sim/weighted_count_cluster_stats_top_tb.sv */
// testbench top: stimulus, receiver stalls and verdict for the cluster statistics block
`timescale 1ns / 1ps

module weighted_count_cluster_stats_top_tb;
  localparam bit MODE_ADD = 1'b0;
  localparam bit MODE_REMOVE = 1'b1;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_mode;
  logic [15:0]        in_total_size;
  logic [15:0]        in_count;
  logic               in_last;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] out_score;
  logic signed [63:0] out_total_ss;
  logic               cfg_we;
  logic [3:0]         cfg_wdata;
  int                 failures;
  int                 pending;
  int                 burst_left;
  int                 words_sent;
  int                 cycle_no;
  logic [3:0]         cur_cats;

  weighted_count_cluster_stats_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_total_size(in_total_size), .in_count(in_count), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_score(out_score), .out_total_ss(out_total_ss),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  weighted_count_cluster_stats_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_total_size(in_total_size), .in_count(in_count), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_score(out_score), .out_total_ss(out_total_ss),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .failures(failures), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // receiver: stall pattern, one long hold-off while the sender keeps going
  always @(negedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= 3000 && cycle_no < 3600) out_ready <= 1'b0;
    else if ((cycle_no / 500) % 3 == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_word(bit rem, logic [15:0] s, logic [15:0] x, bit lst);
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= rem;
    in_total_size <= s;
    in_count <= x;
    in_last <= lst;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
  endtask

  // one count vector, counts split out of the total size
  task automatic send_vector(bit rem, logic [15:0] s, int n);
    int left;
    int x;
    left = s;
    for (int k = 0; k < n; k++) begin
      x = (k == n - 1) ? left : $urandom_range(0, left);
      left -= x;
      send_word(rem, s, x[15:0], k == n - 1);
    end
  endtask

  task automatic write_cats(logic [3:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cur_cats = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hffff;
      2, 3: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 20));
    endcase
  endfunction

  task automatic random_phase(int words);
    int  n;
    bit  rem;
    int  stop_at;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      rem = ($urandom_range(0, 9) < 3) ? MODE_REMOVE : MODE_ADD;
      if ($urandom_range(0, 6) != 0) n = (cur_cats == 0) ? $urandom_range(1, 3)
                                          : ((cur_cats > 8) ? 8 : cur_cats);
      else n = $urandom_range(1, 10);
      if ($urandom_range(0, 19) == 0) begin
        for (int k = 0; k < n; k++)
          send_word(rem, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    k == n - 1);
      end else begin
        send_vector(rem, pick_size(), n);
      end
    end
  endtask

  initial begin
    logic [3:0] cat_list[6] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_ADD;
    in_total_size = '0;
    in_count = '0;
    in_last = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 4'd8;
    words_sent = 0;
    burst_left = 4;
    cur_cats = 4'd8;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    write_cats(4'd8);

    // directed: extremes, zero size, removal to empty, partial removal, odd lengths
    send_word(MODE_ADD, 16'hffff, 16'hffff, 1'b0);
    send_word(MODE_ADD, 16'hffff, 16'h0000, 1'b1);
    send_word(MODE_ADD, 16'd0, 16'd0, 1'b1);
    send_vector(MODE_REMOVE, 16'd0, 2);
    send_vector(MODE_ADD, 16'd3, 8);
    send_vector(MODE_REMOVE, 16'd3, 8);
    send_vector(MODE_REMOVE, 16'hffff, 3);
    send_vector(MODE_ADD, 16'd200, 4);
    send_word(MODE_ADD, 16'd7, 16'hffff, 1'b0);
    send_word(MODE_ADD, 16'd9, 16'd1, 1'b1);
    random_phase(80);

    foreach (cat_list[i]) begin
      write_cats(cat_list[i]);
      random_phase(80);
    end
    write_cats(4'd8);
    random_phase(40);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (failures == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
